// ----- rtl/trm_pkg.sv -----
// types, opcodes and helpers for the tiny register machine execute block
// no dependencies; used by trm_exec, the top level and the bench
package trm_pkg;

    localparam int REG_COUNT     = 16;
    localparam int REG_AW        = 4;
    localparam int DATA_WIDTH    = 32;
    localparam int MEM_DEPTH_DEF = 256;
    localparam int PC_W          = 9;

    typedef enum logic [7:0] {
        OP_MOV    = 8'h00,
        OP_ADD    = 8'h01,
        OP_SUB    = 8'h02,
        OP_MUL    = 8'h03,
        OP_IFSM   = 8'h04,
        OP_SET    = 8'h05,
        OP_JMP    = 8'hFB,
        OP_INPUT  = 8'hFC,
        OP_OUTPUT = 8'hFD,
        OP_LOAD   = 8'hFE,
        OP_STORE  = 8'hFF
    } t_opcode;

    typedef struct packed {
        logic [7:0]         mode;
        logic [7:0]         operand;
        logic signed [31:0] in_value;
    } t_in_item;

    typedef struct packed {
        logic [PC_W-1:0]    next_pc;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               was_skipped;
        logic               illegal;
    } t_out_item;

    typedef struct packed {
        logic                  reg_we;
        logic [REG_AW-1:0]     reg_waddr;
        logic [DATA_WIDTH-1:0] reg_wdata;
        logic                  mem_we;
        logic [DATA_WIDTH-1:0] mem_wdata;
        logic                  flag_next;
        logic [PC_W-1:0]       pc_next;
    } t_exec_ctl;

    // operand byte modulo the memory depth; recip is ceil(65536 / depth), exact for 8-bit values
    function automatic logic [7:0] mem_index(input logic [7:0] value, input int depth,
                                             input int recip);
        logic [23:0] prod;
        logic [15:0] back;
        prod = 24'(value) * 24'(recip);
        back = 16'(prod[23:16]) * 16'(depth);
        return value - back[7:0];
    endfunction

endpackage

// ----- rtl/trm_ram.sv -----
// generic single write port RAM with registered read and read enable
// no dependencies
module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/trm_exec.sv -----
// instruction decode and alu for one instruction held in the input register
// depends on trm_pkg
module trm_exec (
    input  logic                             i_fire,
    input  trm_pkg::t_in_item                i_item,
    input  logic [trm_pkg::DATA_WIDTH-1:0]   i_rd_a,
    input  logic [trm_pkg::DATA_WIDTH-1:0]   i_rd_b,
    input  logic [trm_pkg::DATA_WIDTH-1:0]   i_mem_q,
    input  logic [trm_pkg::PC_W-1:0]         i_pc,
    input  logic                             i_flag,
    output trm_pkg::t_exec_ctl               o_ctl,
    output trm_pkg::t_out_item               o_res
);

    import trm_pkg::*;

    logic [REG_AW-1:0] dst;
    logic [REG_AW-1:0] src;
    logic              legal;
    logic              reg_we;
    logic              mem_we;

    assign dst = i_item.operand[7:4];
    assign src = i_item.operand[3:0];

    always_comb begin
        legal = (i_item.mode inside {[OP_MOV:OP_SET], [OP_JMP:OP_STORE]});
    end

    always_comb begin
        reg_we            = 1'b0;
        mem_we            = 1'b0;
        o_ctl             = '0;
        o_ctl.reg_waddr   = dst;
        o_ctl.mem_wdata   = i_rd_a;
        o_ctl.flag_next   = i_flag;
        o_ctl.pc_next     = i_pc + PC_W'(1);
        o_res             = '0;
        o_res.illegal     = ~legal;

        if (!i_flag) begin
            o_ctl.flag_next   = 1'b1;
            o_res.was_skipped = 1'b1;
        end else if (!legal) begin
            o_ctl.pc_next = i_pc;
        end else begin
            case (i_item.mode)
                OP_MOV: begin
                    reg_we          = 1'b1;
                    o_ctl.reg_wdata = i_rd_b;
                end
                OP_ADD: begin
                    reg_we          = 1'b1;
                    o_ctl.reg_wdata = i_rd_a + i_rd_b;
                end
                OP_SUB: begin
                    reg_we          = 1'b1;
                    o_ctl.reg_wdata = i_rd_a - i_rd_b;
                end
                OP_MUL: begin
                    reg_we          = 1'b1;
                    o_ctl.reg_wdata = i_rd_a * i_rd_b;
                end
                OP_IFSM: begin
                    o_ctl.flag_next = ($signed(i_rd_a) < $signed(i_rd_b));
                end
                OP_SET: begin
                    reg_we          = 1'b1;
                    o_ctl.reg_wdata = DATA_WIDTH'(src);
                end
                OP_JMP: begin
                    o_ctl.pc_next = {1'b0, i_item.operand};
                end
                OP_INPUT: begin
                    reg_we          = 1'b1;
                    o_ctl.reg_waddr = src;
                    o_ctl.reg_wdata = i_item.in_value;
                end
                OP_OUTPUT: begin
                    o_res.out_valid = 1'b1;
                    o_res.out_value = i_rd_b;
                end
                OP_LOAD: begin
                    reg_we          = 1'b1;
                    o_ctl.reg_waddr = '0;
                    o_ctl.reg_wdata = i_mem_q;
                end
                OP_STORE: begin
                    mem_we = 1'b1;
                end
                default: begin
                    o_ctl.pc_next = i_pc;
                end
            endcase
        end

        o_ctl.reg_we  = i_fire & reg_we;
        o_ctl.mem_we  = i_fire & mem_we;
        o_res.next_pc = o_ctl.pc_next;
    end

endmodule

// ----- rtl/tiny_register_machine_execute_top.sv -----
// top level of the tiny register machine execute block
// depends on trm_pkg, trm_ram, trm_exec
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_in  (t_in_item)
//   out      output     o_out_valid / i_out_stall  o_out (t_out_item)
//
// one instruction per cycle unless the output stalls; results are registered
// register file and data memory are read when a transaction is taken, and the
// write of the instruction executing in that cycle is forwarded
// i_rst_n is synchronous: pc 0, flag 1, register file and memory read as zero
// a stalled output holds the input register, which then stalls the input
module tiny_register_machine_execute_top #(
    parameter int MEM_DEPTH = trm_pkg::MEM_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  trm_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output trm_pkg::t_out_item o_out
);

    import trm_pkg::*;

    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int MEM_RECIP = (65536 + MEM_DEPTH - 1) / MEM_DEPTH;

    logic                  r_in_valid;
    t_in_item              r_in;
    logic [MEM_AW-1:0]     r_maddr;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic [PC_W-1:0]       r_pc;
    logic                  r_flag;
    logic [REG_COUNT-1:0]  r_rf_valid;
    logic [MEM_DEPTH-1:0]  r_mem_valid;
    logic                  r_byp_a_hit;
    logic                  r_byp_b_hit;
    logic                  r_byp_m_hit;
    logic [DATA_WIDTH-1:0] r_byp_a_data;
    logic [DATA_WIDTH-1:0] r_byp_b_data;
    logic [DATA_WIDTH-1:0] r_byp_m_data;

    logic                  fire;
    logic                  accept;
    logic [REG_AW-1:0]     rd_a_addr;
    logic [REG_AW-1:0]     rd_b_addr;
    logic [MEM_AW-1:0]     mem_raddr;
    logic [REG_AW-1:0]     ex_a_addr;
    logic [REG_AW-1:0]     ex_b_addr;
    logic [DATA_WIDTH-1:0] q_a;
    logic [DATA_WIDTH-1:0] q_b;
    logic [DATA_WIDTH-1:0] q_m;
    logic [DATA_WIDTH-1:0] rd_a;
    logic [DATA_WIDTH-1:0] rd_b;
    logic [DATA_WIDTH-1:0] mem_q;
    t_exec_ctl             ctl;
    t_out_item             exec_res;

    assign fire       = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~fire;
    assign accept     = i_in_valid & ~o_in_stall;

    // port a reads r0 for store, the destination otherwise
    assign rd_a_addr = (i_in.mode == OP_STORE) ? REG_AW'(0) : i_in.operand[7:4];
    assign rd_b_addr = i_in.operand[3:0];
    assign mem_raddr = MEM_AW'(mem_index(i_in.operand, MEM_DEPTH, MEM_RECIP));
    assign ex_a_addr = (r_in.mode == OP_STORE) ? REG_AW'(0) : r_in.operand[7:4];
    assign ex_b_addr = r_in.operand[3:0];

    trm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (REG_COUNT)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (ctl.reg_we),
        .i_waddr (ctl.reg_waddr),
        .i_wdata (ctl.reg_wdata),
        .i_re    (accept),
        .i_raddr (rd_a_addr),
        .o_rdata (q_a)
    );

    trm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (REG_COUNT)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (ctl.reg_we),
        .i_waddr (ctl.reg_waddr),
        .i_wdata (ctl.reg_wdata),
        .i_re    (accept),
        .i_raddr (rd_b_addr),
        .o_rdata (q_b)
    );

    trm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (ctl.mem_we),
        .i_waddr (r_maddr),
        .i_wdata (ctl.mem_wdata),
        .i_re    (accept),
        .i_raddr (mem_raddr),
        .o_rdata (q_m)
    );

    always_comb begin
        rd_a  = r_byp_a_hit ? r_byp_a_data : (r_rf_valid[ex_a_addr] ? q_a : '0);
        rd_b  = r_byp_b_hit ? r_byp_b_data : (r_rf_valid[ex_b_addr] ? q_b : '0);
        mem_q = r_byp_m_hit ? r_byp_m_data : (r_mem_valid[r_maddr] ? q_m : '0);
    end

    trm_exec u_exec (
        .i_fire  (fire),
        .i_item  (r_in),
        .i_rd_a  (rd_a),
        .i_rd_b  (rd_b),
        .i_mem_q (mem_q),
        .i_pc    (r_pc),
        .i_flag  (r_flag),
        .o_ctl   (ctl),
        .o_res   (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_flag      <= 1'b1;
            r_rf_valid  <= '0;
            r_mem_valid <= '0;
            r_byp_a_hit <= 1'b0;
            r_byp_b_hit <= 1'b0;
            r_byp_m_hit <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid  <= 1'b1;
                r_byp_a_hit <= ctl.reg_we & (ctl.reg_waddr == rd_a_addr);
                r_byp_b_hit <= ctl.reg_we & (ctl.reg_waddr == rd_b_addr);
                r_byp_m_hit <= ctl.mem_we & (r_maddr == mem_raddr);
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_pc        <= ctl.pc_next;
                r_flag      <= ctl.flag_next;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (ctl.reg_we) begin
                r_rf_valid[ctl.reg_waddr] <= 1'b1;
            end
            if (ctl.mem_we) begin
                r_mem_valid[r_maddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in         <= i_in;
            r_maddr      <= mem_raddr;
            r_byp_a_data <= ctl.reg_wdata;
            r_byp_b_data <= ctl.reg_wdata;
            r_byp_m_data <= ctl.mem_wdata;
        end
        if (fire) begin
            r_out <= exec_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_skip_restores_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_flag |=> r_flag)
        else $error("flag not restored after a skipped instruction");

    a_skip_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !r_flag |-> !ctl.reg_we && !ctl.mem_we)
        else $error("skipped instruction wrote state");

    a_illegal_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_flag && exec_res.illegal |=> r_pc == $past(r_pc))
        else $error("illegal instruction moved the program counter");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled while the pipeline can advance");

endmodule

// ----- bench/trm_execute_checker.sv -----
`timescale 1ns / 1ps
// checker for tiny_register_machine_execute_top: keeps its own machine state, predicts
// the result of every input transaction and compares output transactions in order
// depends on trm_pkg
module trm_execute_checker #(
    parameter int MEM_DEPTH = trm_pkg::MEM_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  trm_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  trm_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_results_done
);

    import trm_pkg::*;

    logic [DATA_WIDTH-1:0] regs [REG_COUNT];
    logic [DATA_WIDTH-1:0] dmem [MEM_DEPTH];
    logic [PC_W-1:0]       mach_pc;
    logic                  mach_flag;
    t_out_item             expected_results [$];
    int                    fail_total = 0;
    int                    done_total = 0;

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        fail_total++;
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want_v, got_v);
    endtask

    task automatic add_expected(input t_out_item res);
        expected_results.insert(expected_results.size(), res);
    endtask

    // executes one instruction on the local machine state
    function automatic t_out_item execute_instr(input t_in_item it);
        t_out_item       res;
        logic [3:0]      dst;
        logic [3:0]      src;
        logic [PC_W-1:0] pc_after;
        logic            legal;
        int              midx;
        res      = '0;
        dst      = it.operand[7:4];
        src      = it.operand[3:0];
        midx     = it.operand % MEM_DEPTH;
        pc_after = mach_pc + 1'b1;
        case (it.mode)
            OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_IFSM, OP_SET,
            OP_JMP, OP_INPUT, OP_OUTPUT, OP_LOAD, OP_STORE: legal = 1'b1;
            default: legal = 1'b0;
        endcase
        if (!mach_flag) begin
            mach_flag       = 1'b1;
            res.was_skipped = 1'b1;
        end else if (!legal) begin
            pc_after = mach_pc;
        end else begin
            case (it.mode)
                OP_MOV:    regs[dst] = regs[src];
                OP_ADD:    regs[dst] = regs[dst] + regs[src];
                OP_SUB:    regs[dst] = regs[dst] - regs[src];
                OP_MUL:    regs[dst] = regs[dst] * regs[src];
                OP_IFSM:   mach_flag = $signed(regs[dst]) < $signed(regs[src]);
                OP_SET:    regs[dst] = DATA_WIDTH'(src);
                OP_JMP:    pc_after = PC_W'(it.operand);
                OP_INPUT:  regs[src] = it.in_value;
                OP_OUTPUT: begin
                    res.out_valid = 1'b1;
                    res.out_value = regs[src];
                end
                OP_LOAD:   regs[0] = dmem[midx];
                default:   dmem[midx] = regs[0];
            endcase
        end
        mach_pc     = pc_after;
        res.next_pc = pc_after;
        res.illegal = !legal;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) regs[k] = '0;
            for (int k = 0; k < MEM_DEPTH; k++) dmem[k] = '0;
            mach_pc   = '0;
            mach_flag = 1'b1;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                add_expected(execute_instr(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, 32'(i_out.next_pc));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.next_pc !== want.next_pc)
                        report_mismatch("next_pc", 32'(want.next_pc), 32'(i_out.next_pc));
                    if (i_out.out_valid !== want.out_valid)
                        report_mismatch("out_valid", 32'(want.out_valid),
                                        32'(i_out.out_valid));
                    if (i_out.out_value !== want.out_value)
                        report_mismatch("out_value", want.out_value, i_out.out_value);
                    if (i_out.was_skipped !== want.was_skipped)
                        report_mismatch("was_skipped", 32'(want.was_skipped),
                                        32'(i_out.was_skipped));
                    if (i_out.illegal !== want.illegal)
                        report_mismatch("illegal", 32'(want.illegal), 32'(i_out.illegal));
                    done_total++;
                end
            end
        end
        o_fail_count   <= fail_total;
        o_results_done <= done_total;
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for tiny_register_machine_execute_top: clock, reset, stimulus, output
// stall pattern, watchdog and verdict; depends on trm_pkg, the top and trm_execute_checker
module tb_top;
    import trm_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 10;

    localparam logic [7:0] ILLEGAL_LOW  = 8'h06;
    localparam logic [7:0] ILLEGAL_MID  = 8'h80;
    localparam logic [7:0] ILLEGAL_HIGH = 8'hFA;

    localparam int STALL_NONE      = 0;
    localparam int STALL_LIGHT     = 1;
    localparam int STALL_HEAVY     = 2;
    localparam int STALL_ALTERNATE = 3;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;
    logic      hold_req;
    int        fail_count;
    int        results_done;
    int        items_sent = 0;
    int        burst_left = 0;
    int        quiet_cycles = 0;
    t_in_item  directed_items [$];

    always #5 i_clk = ~i_clk;

    tiny_register_machine_execute_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    trm_execute_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .o_fail_count  (fail_count),
        .o_results_done(results_done)
    );

    function automatic t_in_item mk(input logic [7:0] mode, input logic [7:0] operand,
                                    input logic [31:0] value);
        t_in_item it;
        it.mode     = mode;
        it.operand  = operand;
        it.in_value = value;
        return it;
    endfunction

    task automatic add_directed(input t_in_item it);
        directed_items.insert(directed_items.size(), it);
    endtask

    function automatic t_in_item rand_item(input bit allow_jump);
        t_in_item it;
        int       pick;
        if ($urandom_range(0, 99) < 12) begin
            it.mode = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 10))
                0:       it.mode = OP_MOV;
                1:       it.mode = OP_ADD;
                2:       it.mode = OP_SUB;
                3:       it.mode = OP_MUL;
                4:       it.mode = OP_IFSM;
                5:       it.mode = OP_SET;
                6:       it.mode = OP_JMP;
                7:       it.mode = OP_INPUT;
                8:       it.mode = OP_OUTPUT;
                9:       it.mode = OP_LOAD;
                default: it.mode = OP_STORE;
            endcase
        end
        if (!allow_jump && it.mode == OP_JMP) it.mode = OP_SET;
        it.operand = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        case (pick)
            0:       it.in_value = 32'h7FFF_FFFF;
            1:       it.in_value = 32'h8000_0000;
            2:       it.in_value = 32'hFFFF_FFFF;
            3:       it.in_value = 32'h0;
            4, 5:    it.in_value = $urandom_range(0, 31);
            6:       it.in_value = -$signed(32'($urandom_range(1, 31)));
            default: it.in_value = $urandom;
        endcase
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // bursts of random length with random gaps in between
    task automatic offer_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (results_done != items_sent) @(posedge i_clk);
    endtask

    initial begin : out_stall_gen
        int phase_left;
        int pattern;
        bit hold_done;
        phase_left = 0;
        pattern    = STALL_NONE;
        hold_done  = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done   = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    pattern    = $urandom_range(STALL_NONE, STALL_ALTERNATE);
                    phase_left = $urandom_range(20, 300);
                end
                phase_left--;
                case (pattern)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= phase_left[0];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tiny_register_machine_execute_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        hold_req   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, wrap, skip after a false compare, illegal codes, memory ends, jumps
        add_directed(mk(OP_INPUT,  8'h01, 32'h7FFF_FFFF));
        add_directed(mk(OP_INPUT,  8'hF2, 32'h8000_0000));
        add_directed(mk(OP_INPUT,  8'h0F, 32'hFFFF_FFFF));
        add_directed(mk(OP_SET,    8'h31, 32'hFFFF_FFFF));
        add_directed(mk(OP_ADD,    8'h13, 32'h0));
        add_directed(mk(OP_SUB,    8'h2F, 32'h0));
        add_directed(mk(OP_MUL,    8'hFF, 32'h0));
        add_directed(mk(OP_IFSM,   8'h21, 32'h0));
        add_directed(mk(OP_OUTPUT, 8'h01, 32'h0));
        add_directed(mk(OP_IFSM,   8'h12, 32'h0));
        add_directed(mk(OP_OUTPUT, 8'h02, 32'h0));
        add_directed(mk(OP_IFSM,   8'h11, 32'h0));
        add_directed(mk(ILLEGAL_MID,  8'h00, 32'h0));
        add_directed(mk(ILLEGAL_LOW,  8'h55, 32'h0));
        add_directed(mk(ILLEGAL_HIGH, 8'hAA, 32'hFFFF_FFFF));
        add_directed(mk(OP_MOV,    8'h02, 32'h0));
        add_directed(mk(OP_STORE,  8'hFF, 32'h0));
        add_directed(mk(OP_SET,    8'h0F, 32'h0));
        add_directed(mk(OP_STORE,  8'h00, 32'h0));
        add_directed(mk(OP_LOAD,   8'hFF, 32'h0));
        add_directed(mk(OP_OUTPUT, 8'hF0, 32'h0));
        add_directed(mk(OP_MUL,    8'h12, 32'h0));
        add_directed(mk(OP_JMP,    8'hFF, 32'h0));
        add_directed(mk(OP_JMP,    8'h00, 32'h0));
        add_directed(mk(OP_OUTPUT, 8'hEF, 32'h0));
        foreach (directed_items[k]) send_item(directed_items[k]);

        for (int n = 0; n < 900; n++) begin
            if (n == 200) hold_req <= 1'b1;
            offer_item(rand_item(1'b1));
        end
        wait_drained();

        // no jumps for a while so the counter runs past 511 and wraps
        send_item(mk(OP_JMP, 8'hFF, 32'h0));
        for (int n = 0; n < 340; n++) offer_item(rand_item(1'b0));
        for (int n = 0; n < 685; n++) offer_item(rand_item(1'b1));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tiny_register_machine_execute_top test passed");
        end else begin
            $display("tiny_register_machine_execute_top test failed");
        end
        $finish;
    end

endmodule

// ----- tiny_register_machine_execute_top.f -----
rtl/trm_pkg.sv
rtl/trm_ram.sv
rtl/trm_exec.sv
rtl/tiny_register_machine_execute_top.sv
bench/trm_execute_checker.sv
bench/tb_top.sv
